// ===== hdl/hescr_pkg.sv =====
`timescale 1ns / 1ps

package hescr_pkg;

	localparam int WIN_BYTES = 7;

	typedef logic [WIN_BYTES-1:0][7:0] win_t;

	localparam logic [2:0] WIN_DEPTH  = 3'd7;
	localparam logic [2:0] DECIDE_MIN = 3'd6;
	localparam logic [2:0] ESC_LONG   = 3'd5;
	localparam logic [2:0] ESC_SHORT  = 3'd4;
	localparam logic [2:0] ESC_NONE   = 3'd0;
	localparam logic [2:0] ESC_DROP   = 3'd2;

	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [7:0] BYTE_ONE  = 8'h01;
	localparam logic [7:0] BYTE_ESC  = 8'h03;

	localparam logic [7:0] HDR0_MASK    = 8'h81;
	localparam logic [7:0] LAYER_MASK   = 8'hf8;
	localparam logic [7:0] TID_MASK     = 8'h07;
	localparam logic [5:0] NAL_TYPE_MAX = 6'd40;

	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [1:0] ST_REPAIRED = 2'd0;
	localparam logic [1:0] ST_VALID    = 2'd1;
	localparam logic [1:0] ST_REJECTED = 2'd2;

	localparam int TDATA_W = 32;

	typedef enum logic [1:0] {
		MODE_DECIDING,
		MODE_REPAIR,
		MODE_VALID,
		MODE_REJECTED
	} mode_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_DRAIN,
		PH_FLUSH,
		PH_STATUS
	} phase_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data;
		logic        last;
		logic [1:0]  status;
		logic [15:0] count;
	} result_t;

	function automatic logic plausible(input logic [7:0] b0, input logic [7:0] b1);
		return ((b0 & HDR0_MASK) == BYTE_ZERO) && ((b1 & LAYER_MASK) == BYTE_ZERO) &&
			((b1 & TID_MASK) != BYTE_ZERO) && (b0[6:1] <= NAL_TYPE_MAX);
	endfunction

	function automatic logic [2:0] esc_len(input win_t w, input logic [2:0] fill);
		logic [2:0] len;
		len = ESC_NONE;
		if (fill == WIN_DEPTH && w[0] == BYTE_ZERO && w[1] == BYTE_ZERO &&
			w[2] == BYTE_ESC && w[3] == BYTE_ZERO && w[4] == BYTE_ONE &&
			plausible(w[5], w[6])) begin
			len = ESC_LONG;
		end else if (fill >= DECIDE_MIN && w[0] == BYTE_ZERO && w[1] == BYTE_ZERO &&
			w[2] == BYTE_ESC && w[3] == BYTE_ONE && plausible(w[4], w[5])) begin
			len = ESC_SHORT;
		end
		return len;
	endfunction

endpackage

// ===== hdl/hevc_escaped_start_code_repair_core.sv =====
`timescale 1ns / 1ps

// Repairs escaped start codes in one encoded buffer, one byte per beat, with tlast on the
// final byte. A seven-byte window decides the mode at the buffer start: a buffer that
// already starts with a start code passes unchanged (status 1), one that starts with an
// escaped prefix followed by a plausible NAL header is repaired (status 0), anything else
// or a buffer under six bytes passes unchanged (status 2). In repair mode each escaped
// prefix loses its 03 byte. After the last byte the window drains and one status beat
// (tuser high, tlast high) closes the buffer with the saturating repair count. Throughput
// is one byte per cycle in steady flow, set by the single window step between the input
// and the two-entry result buffer. The input stalls while a buffer that is not repaired
// flushes its window, after each repair while the skipped bytes drain, for the window
// drain after the last byte and for the status beat.
module hevc_escaped_start_code_repair_core #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] out_byte, [9:8] status, [25:10] repair_count
	output logic        m_tlast,
	output logic [0:0]  m_tuser    // [0] out_kind
);

	import hescr_pkg::*;

	phase_t                 phase_q, phase_d;
	mode_t                  mode_q, mode_d, amode;
	win_t                   win_q, win_d, aw;
	logic [2:0]             fill_q, fill_d, afill;
	logic [1:0]             skip_q, skip_d;
	logic [COUNT_WIDTH-1:0] rep_q, rep_d;
	logic                   last_q, last_d, alast;
	logic [2:0]             elen;
	logic                   run_drain;
	logic                   take;
	logic                   room;
	logic                   push;
	logic                   pop;
	result_t                push_item;
	result_t                head;
	result_t                buf_q [2];
	logic                   wptr_q, rptr_q;
	logic [1:0]             cnt_q;
	logic [COUNT_WIDTH+15:0] rep_ext;
	logic [1:0]             st_code;

	assign room     = cnt_q != 2'd2;
	assign s_tready = (phase_q == PH_IDLE) && room;
	assign take     = s_tvalid && s_tready;
	assign m_tvalid = cnt_q != 2'd0;
	assign pop      = m_tvalid && m_tready;
	assign head     = buf_q[rptr_q];
	assign m_tdata  = {6'd0, head.count, head.status, head.data};
	assign m_tlast  = head.last;
	assign m_tuser  = head.kind;
	assign rep_ext  = {16'd0, rep_q};
	assign elen     = esc_len(aw, afill);

	always_comb begin
		case (mode_q)
			MODE_REPAIR: st_code = ST_REPAIRED;
			MODE_VALID:  st_code = ST_VALID;
			default:     st_code = ST_REJECTED;
		endcase
	end

	always_comb begin
		phase_d   = phase_q;
		mode_d    = mode_q;
		win_d     = win_q;
		fill_d    = fill_q;
		skip_d    = skip_q;
		rep_d     = rep_q;
		last_d    = last_q;
		aw        = win_q;
		afill     = fill_q;
		amode     = mode_q;
		alast     = last_q;
		run_drain = 1'b0;
		push      = 1'b0;
		push_item = '0;

		case (phase_q)
			PH_IDLE: begin
				if (take) begin
					alast  = s_tlast;
					last_d = s_tlast;
					if (mode_q == MODE_VALID || mode_q == MODE_REJECTED) begin
						push           = 1'b1;
						push_item.kind = KIND_DATA;
						push_item.data = s_tdata;
					end else if (fill_q < WIN_DEPTH) begin
						aw[fill_q] = s_tdata;
						afill      = fill_q + 3'd1;
					end
					if (mode_q == MODE_DECIDING && (afill == WIN_DEPTH || s_tlast)) begin
						if (afill < DECIDE_MIN)
							amode = MODE_REJECTED;
						else if (aw[0] == BYTE_ZERO && aw[1] == BYTE_ZERO &&
							(aw[2] == BYTE_ONE || (aw[2] == BYTE_ZERO && aw[3] == BYTE_ONE)))
							amode = MODE_VALID;
						else if (elen != ESC_NONE)
							amode = MODE_REPAIR;
						else
							amode = MODE_REJECTED;
					end
					mode_d = amode;
					if (amode == MODE_REPAIR) begin
						run_drain = 1'b1;
					end else if (amode == MODE_DECIDING) begin
						win_d  = aw;
						fill_d = afill;
					end else if (mode_q == MODE_DECIDING) begin
						win_d   = aw;
						fill_d  = afill;
						phase_d = PH_FLUSH;
					end else if (s_tlast) begin
						phase_d = PH_STATUS;
					end
				end
			end
			PH_DRAIN: begin
				if (room)
					run_drain = 1'b1;
			end
			PH_FLUSH: begin
				if (room) begin
					push           = 1'b1;
					push_item.kind = KIND_DATA;
					push_item.data = win_q[0];
					win_d          = {BYTE_ZERO, win_q[6:1]};
					fill_d         = fill_q - 3'd1;
					if (fill_q == 3'd1)
						phase_d = last_q ? PH_STATUS : PH_IDLE;
				end
			end
			PH_STATUS: begin
				if (room) begin
					push             = 1'b1;
					push_item.kind   = KIND_STATUS;
					push_item.last   = 1'b1;
					push_item.status = st_code;
					push_item.count  = (mode_q == MODE_REPAIR) ? rep_ext[15:0] : 16'd0;
					win_d            = '0;
					fill_d           = 3'd0;
					mode_d           = MODE_DECIDING;
					skip_d           = 2'd0;
					rep_d            = '0;
					last_d           = 1'b0;
					phase_d          = PH_IDLE;
				end
			end
			default: phase_d = PH_IDLE;
		endcase

		if (run_drain) begin
			win_d  = aw;
			fill_d = afill;
			if (afill != 3'd0 && (skip_q != 2'd0 || alast || afill == WIN_DEPTH)) begin
				push           = 1'b1;
				push_item.kind = KIND_DATA;
				push_item.data = aw[0];
				if (skip_q == 2'd0 && elen != ESC_NONE) begin
					win_d  = {BYTE_ZERO, BYTE_ZERO, aw[6:3], aw[1]};
					fill_d = afill - 3'd2;
					skip_d = 2'(elen - ESC_DROP);
					if (rep_q != {COUNT_WIDTH{1'b1}})
						rep_d = rep_q + COUNT_WIDTH'(1);
				end else begin
					win_d  = {BYTE_ZERO, aw[6:1]};
					fill_d = afill - 3'd1;
					if (skip_q != 2'd0)
						skip_d = skip_q - 2'd1;
				end
			end
			if (fill_d != 3'd0 && (skip_d != 2'd0 || alast))
				phase_d = PH_DRAIN;
			else if (alast)
				phase_d = PH_STATUS;
			else
				phase_d = PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			phase_q <= PH_IDLE;
		else
			phase_q <= phase_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_DECIDING;
			win_q  <= '0;
			fill_q <= 3'd0;
			skip_q <= 2'd0;
			rep_q  <= '0;
			last_q <= 1'b0;
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			mode_q <= mode_d;
			win_q  <= win_d;
			fill_q <= fill_d;
			skip_q <= skip_d;
			rep_q  <= rep_d;
			last_q <= last_d;
			if (push)
				wptr_q <= ~wptr_q;
			if (pop)
				rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			buf_q[wptr_q] <= push_item;
	end

endmodule

// ===== hdl/hescr_checker.sv =====
`timescale 1ns / 1ps

module hescr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast,
	input logic [0:0]  m_tuser
);

	import hescr_pkg::*;

	logic in_beat;

	assign in_beat = s_tvalid && s_tready && s_tlast && (s_tdata != BYTE_ZERO || s_tdata == BYTE_ZERO);

	a_last_on_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser[0] == KIND_STATUS)))
		else $error("tlast does not mark exactly the status beat");

	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] == KIND_DATA |-> m_tdata[31:8] == 24'd0)
		else $error("data beat carries status or count bits");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] == KIND_STATUS |->
			(m_tdata[7:0] == BYTE_ZERO && m_tdata[31:26] == 6'd0 &&
			(m_tdata[9:8] == ST_REPAIRED || m_tdata[25:10] == 16'd0) &&
			(m_tdata[9:8] == ST_REPAIRED || m_tdata[9:8] == ST_VALID ||
			m_tdata[9:8] == ST_REJECTED)))
		else $error("malformed status beat");

	a_no_input_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !s_tready)
		else $error("input taken right after the final byte");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) &&
			$stable(m_tuser))
		else $error("stalled output beat changed");

endmodule

bind hevc_escaped_start_code_repair_core hescr_checker u_hescr_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import hescr_pkg::*;

	class repair_scoreboard;
		logic [7:0]  win [7];
		int unsigned fill;
		int unsigned skip;
		int unsigned seen;
		mode_t       mode;
		logic [15:0] repairs;
		result_t     expected_q[$];
		int          errors;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			foreach (win[i]) win[i] = 8'h00;
			fill = 0;
			skip = 0;
			seen = 0;
			mode = MODE_DECIDING;
			repairs = '0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void push_data(logic [7:0] b);
			expected_q.push_back('{kind: KIND_DATA, data: b, last: 1'b0, status: 2'd0,
				count: 16'd0});
		endfunction

		function bit nal_hdr_ok(logic [7:0] b0, logic [7:0] b1);
			return b0[7] == 1'b0 && b0[0] == 1'b0 && b1[7:3] == 5'd0 && b1[2:0] != 3'd0 &&
				b0[6:1] <= NAL_TYPE_MAX;
		endfunction

		function int unsigned prefix_len(int unsigned avail);
			if (avail >= 7 && win[0] == BYTE_ZERO && win[1] == BYTE_ZERO && win[2] == BYTE_ESC &&
				win[3] == BYTE_ZERO && win[4] == BYTE_ONE && nal_hdr_ok(win[5], win[6]))
				return 5;
			if (avail >= 6 && win[0] == BYTE_ZERO && win[1] == BYTE_ZERO && win[2] == BYTE_ESC &&
				win[3] == BYTE_ONE && nal_hdr_ok(win[4], win[5]))
				return 4;
			return 0;
		endfunction

		function void drop_at(int unsigned pos);
			if (pos >= fill)
				return;
			for (int unsigned i = pos; i < 6; i++)
				win[i] = win[i + 1];
			win[6] = 8'h00;
			fill--;
		endfunction

		function void drain(bit fin);
			int unsigned e;
			while (fill > 0) begin
				if (skip > 0) begin
					push_data(win[0]);
					drop_at(0);
					skip--;
					continue;
				end
				if (!fin && fill < 7)
					break;
				e = prefix_len(fill);
				push_data(win[0]);
				drop_at(0);
				if (e != 0) begin
					drop_at(1);
					skip = e - 2;
					if (repairs != 16'hffff)
						repairs++;
				end
			end
		endfunction

		function void note_byte(logic [7:0] b, logic fin);
			logic [1:0] st;
			if (seen < 7)
				seen++;
			if (mode == MODE_VALID || mode == MODE_REJECTED)
				push_data(b);
			else if (fill < 7) begin
				win[fill] = b;
				fill++;
			end
			if (mode == MODE_DECIDING && (fill == 7 || fin)) begin
				if (seen < 6)
					mode = MODE_REJECTED;
				else if (win[0] == BYTE_ZERO && win[1] == BYTE_ZERO && (win[2] == BYTE_ONE ||
					(win[2] == BYTE_ZERO && win[3] == BYTE_ONE)))
					mode = MODE_VALID;
				else if (prefix_len(fill) != 0)
					mode = MODE_REPAIR;
				else
					mode = MODE_REJECTED;
				if (mode != MODE_REPAIR) begin
					for (int unsigned i = 0; i < fill; i++)
						push_data(win[i]);
					foreach (win[i]) win[i] = 8'h00;
					fill = 0;
				end
			end
			if (mode == MODE_REPAIR)
				drain(fin);
			if (fin) begin
				st = (mode == MODE_REPAIR) ? ST_REPAIRED :
					(mode == MODE_VALID) ? ST_VALID : ST_REJECTED;
				expected_q.push_back('{kind: KIND_STATUS, data: 8'h00, last: 1'b1, status: st,
					count: (mode == MODE_REPAIR) ? repairs : 16'd0});
				clear();
			end
		endfunction

		task report(string what);
			errors++;
			if (errors <= 50)
				$display("%0t mismatch: %s", $time, what);
		endtask

		task check_beat(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected beat kind %0d byte %02h", got.kind, got.data));
				return;
			end
			want = expected_q.pop_front();
			if (got.kind != want.kind)
				report($sformatf("kind %0d, want %0d", got.kind, want.kind));
			if (got.data != want.data)
				report($sformatf("byte %02h, want %02h", got.data, want.data));
			if (got.last != want.last)
				report($sformatf("last %0d, want %0d", got.last, want.last));
			if (got.status != want.status)
				report($sformatf("status %0d, want %0d", got.status, want.status));
			if (got.count != want.count)
				report($sformatf("repair count %0d, want %0d", got.count, want.count));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic [0:0]  m_tuser;

	repair_scoreboard sb = new();
	logic [7:0] frame_q[$];
	int sent_items = 0;
	int send_idle_pct = 8;
	int recv_idle_pct = 59;
	int hold_reqs = 0;
	int holds_done = 0;

	hevc_escaped_start_code_repair_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	always @(posedge clk) begin
		result_t got;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				got.kind   = m_tuser[0];
				got.data   = m_tdata[7:0];
				got.last   = m_tlast;
				got.status = m_tdata[9:8];
				got.count  = m_tdata[25:10];
				sb.check_beat(got);
			end
		end
	end

	// hold off for a long stretch on request, else stall at random
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_reqs != holds_done) begin
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				holds_done++;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	function automatic logic [7:0] rnd_byte();
		case ($urandom_range(9))
			0, 1:    return BYTE_ZERO;
			2:       return BYTE_ESC;
			3:       return BYTE_ONE;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic add_prefix(input bit long_form);
		frame_q.push_back(BYTE_ZERO);
		frame_q.push_back(BYTE_ZERO);
		frame_q.push_back(BYTE_ESC);
		if (long_form)
			frame_q.push_back(BYTE_ZERO);
		frame_q.push_back(BYTE_ONE);
	endtask

	task automatic add_header(input bit good);
		logic [7:0] b0;
		logic [7:0] b1;
		b0 = {1'b0, 6'($urandom_range(NAL_TYPE_MAX)), 1'b0};
		b1 = {5'd0, 3'($urandom_range(7, 1))};
		if (!good) begin
			case ($urandom_range(4))
				0:       b0[7] = 1'b1;
				1:       b0[0] = 1'b1;
				2:       b0[6:1] = 6'($urandom_range(63, 41));
				3:       b1[7:3] = 5'($urandom_range(31, 1));
				default: b1[2:0] = 3'd0;
			endcase
		end
		frame_q.push_back(b0);
		frame_q.push_back(b1);
	endtask

	task automatic send_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= fin;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent_items++;
	endtask

	task automatic send_frame();
		foreach (frame_q[i])
			send_byte(frame_q[i], i == frame_q.size() - 1);
		frame_q.delete();
	endtask

	task automatic make_frame();
		int n;
		int r;
		r = $urandom_range(99);
		if (r < 60) begin
			add_prefix($urandom_range(1));
			add_header(1'b1);
			n = $urandom_range(25);
			for (int i = 0; i < n; i++) begin
				r = $urandom_range(99);
				if (r < 15) begin
					add_prefix($urandom_range(1));
					add_header(1'b1);
				end else if (r < 20) begin
					add_prefix($urandom_range(1));
					add_header(1'b0);
				end else if (r < 25) begin
					add_prefix($urandom_range(1));
				end else begin
					frame_q.push_back(rnd_byte());
				end
			end
		end else if (r < 75) begin
			frame_q.push_back(BYTE_ZERO);
			frame_q.push_back(BYTE_ZERO);
			if ($urandom_range(1))
				frame_q.push_back(BYTE_ZERO);
			frame_q.push_back(BYTE_ONE);
			n = $urandom_range(20, 2);
			for (int i = 0; i < n; i++)
				frame_q.push_back(rnd_byte());
		end else if (r < 85) begin
			n = $urandom_range(5, 1);
			for (int i = 0; i < n; i++)
				frame_q.push_back(rnd_byte());
		end else if (r < 92) begin
			add_prefix($urandom_range(1));
			add_header(1'b0);
			n = $urandom_range(8);
			for (int i = 0; i < n; i++)
				frame_q.push_back(rnd_byte());
		end else begin
			n = $urandom_range(20, 6);
			for (int i = 0; i < n; i++)
				frame_q.push_back(rnd_byte());
		end
	endtask

	initial begin
		bit held;
		bit paused;
		held = 1'b0;
		paused = 1'b0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= 8'h00;
		s_tlast  <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short prefix decided at the last byte, type 40 header
		frame_q = '{8'h00, 8'h00, 8'h03, 8'h01, 8'h50, 8'h01};
		send_frame();
		// start code, but under six bytes
		frame_q = '{8'h00, 8'h00, 8'h01, 8'hff, 8'h80};
		send_frame();
		frame_q = '{8'h00, 8'h00, 8'h01, 8'h80, 8'hff, 8'h00};
		send_frame();
		// long prefix, then one with a type 41 header, then a bare prefix at the end
		frame_q = '{8'h00, 8'h00, 8'h03, 8'h00, 8'h01, 8'h02, 8'h07, 8'h00,
			8'h00, 8'h03, 8'h01, 8'h52, 8'h01, 8'h00, 8'h00, 8'h03};
		send_frame();

		while (sent_items < 320) begin
			if (sent_items >= 250) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (sent_items >= 140) begin
				send_idle_pct = 59;
				recv_idle_pct = 8;
			end
			if (!held && sent_items >= 80) begin
				hold_reqs++;
				held = 1'b1;
			end
			if (!paused && sent_items >= 190) begin
				paused = 1'b1;
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (sb.pending() != 0)
					@(posedge clk);
			end
			make_frame();
			send_frame();
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
